@@ hw/rtl/tkst_pkg.sv @@
// ----------------------------------------------------------------------------
// tkst_pkg
// Shared constants and types for the top-k score table update block.
// ----------------------------------------------------------------------------
package tkst_pkg;

  // Table depth (2 to 15)
  localparam int TABLE_ENTRIES = 10;

  // Index into the table, and position counter that can also hold TABLE_ENTRIES
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int POS_W = $clog2(TABLE_ENTRIES + 1);

  // Checksum walk: TABLE_ENTRIES scores, then counter, frame low, frame high
  localparam int SUM_STEPS = TABLE_ENTRIES + 3;
  localparam int STEP_W    = $clog2(SUM_STEPS);

  localparam int SCORE_W = 16;
  localparam int CNT_W   = 16;
  localparam int FRAME_W = 32;
  localparam int RANK_W  = 4;
  localparam int CHK_W   = 16;

  // Checksum weights
  localparam int WGT_COUNT    = 13;
  localparam int WGT_FRAME_LO = 14;
  localparam int WGT_FRAME_HI = 15;
  localparam int WGT_MAX      = (TABLE_ENTRIES + 2 > WGT_FRAME_HI) ?
                                (TABLE_ENTRIES + 2) : WGT_FRAME_HI;
  localparam int WGT_W        = $clog2(WGT_MAX + 1);

  // Record signature folds into the checksum seed: low half plus twice high half
  localparam logic [31:0]      SIG_WORD = 32'h024E424F;
  localparam logic [CHK_W-1:0] CHK_SEED = CHK_W'(SIG_WORD[15:0] + (SIG_WORD[31:16] << 1));

  // Control word for the shared multiply-accumulate unit
  typedef struct packed {
    logic load;   // acc <= seed
    logic step;   // acc <= acc + operand * weight
  } mac_ctrl_t;

endpackage

@@ hw/rtl/tkst_play_if.sv @@
// ----------------------------------------------------------------------------
// tkst_play_if
// Input channel: one finished play (score and frame count) per word.
// ----------------------------------------------------------------------------
interface tkst_play_if import tkst_pkg::*;;
  logic               valid;
  logic               ready;
  logic [SCORE_W-1:0] new_score;
  logic [FRAME_W-1:0] play_frames_added;

  modport source (output valid, output new_score, output play_frames_added, input ready);
  modport sink   (input valid, input new_score, input play_frames_added, output ready);
endinterface

@@ hw/rtl/tkst_result_if.sv @@
// ----------------------------------------------------------------------------
// tkst_result_if
// Output channel: rank, record checksum and play count per word.
// ----------------------------------------------------------------------------
interface tkst_result_if import tkst_pkg::*;;
  logic             valid;
  logic             ready;
  logic [RANK_W-1:0] rank;
  logic [CHK_W-1:0]  record_checksum;
  logic [CNT_W-1:0]  plays_so_far;

  modport source (output valid, output rank, output record_checksum, output plays_so_far,
                  input ready);
  modport sink   (input valid, input rank, input record_checksum, input plays_so_far,
                  output ready);
endinterface

@@ hw/rtl/tkst_mac.sv @@
// ----------------------------------------------------------------------------
// tkst_mac
// Shared 16-bit multiply-accumulate unit, accumulator wraps modulo 2^16.
// ----------------------------------------------------------------------------
module tkst_mac import tkst_pkg::*; (
  input  logic             clk,
  input  mac_ctrl_t        ctrl,
  input  logic [CHK_W-1:0] operand,
  input  logic [WGT_W-1:0] weight,
  output logic [CHK_W-1:0] acc
);

  logic [CHK_W+WGT_W-1:0] product;
  logic [CHK_W-1:0]       acc_next;

  assign product  = operand * weight;
  assign acc_next = acc + product[CHK_W-1:0];

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      acc <= CHK_SEED;
    end else if (ctrl.step) begin
      acc <= acc_next;
    end
  end

endmodule

@@ hw/rtl/top_k_score_table_update.sv @@
// ----------------------------------------------------------------------------
// top_k_score_table_update
// Keeps a descending table of the best scores, a play counter and a frame
// total; each play word gets its rank, the new count and a record checksum.
// ----------------------------------------------------------------------------
// Flow: a play word is taken only in ST_IDLE; the insertion walk then moves one
//   entry per cycle up from the bottom, and the single MAC walks the checksum
//   terms. The next play word is taken only after the result register has
//   taken the result, so a result that is held also holds the block.
// Reset (rst, synchronous): table, counter and frame total cleared, no result.
// ----------------------------------------------------------------------------
module top_k_score_table_update import tkst_pkg::*; (
  input logic          clk,
  input logic          rst,
  tkst_play_if.sink    play,
  tkst_result_if.source result
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_SUM,
    ST_DONE
  } state_t;

  state_t state;

  // Record state
  logic [SCORE_W-1:0] best_scores [TABLE_ENTRIES];
  logic [CNT_W-1:0]   play_counter;
  logic [FRAME_W-1:0] frame_total;

  // Captured play word
  logic [SCORE_W-1:0] score_q;
  logic [FRAME_W-1:0] frames_q;

  // Sequencer counters: pos walks up from the bottom, step walks the checksum terms
  logic [POS_W-1:0]  pos;
  logic [STEP_W-1:0] step;

  // Result register
  logic              res_valid;
  logic [RANK_W-1:0] res_rank;
  logic [CHK_W-1:0]  res_chk;
  logic [CNT_W-1:0]  res_plays;
  logic              res_load;

  // Single table read port, shared by the insertion walk and the checksum walk
  logic [IDX_W-1:0]   rd_idx;
  logic [SCORE_W-1:0] rd_data;
  logic [IDX_W-1:0]   wr_idx;
  logic               pos_at_top;
  logic               pos_in_table;
  logic               shift_down;

  // Shared MAC
  mac_ctrl_t        mac_ctrl;
  logic [CHK_W-1:0] mac_operand;
  logic [WGT_W-1:0] mac_weight;
  logic [CHK_W-1:0] mac_acc;

  always_comb begin
    if (state == ST_INSERT) begin
      rd_idx = IDX_W'(pos - POS_W'(1));
    end else if (step < STEP_W'(TABLE_ENTRIES)) begin
      rd_idx = IDX_W'(step);
    end else begin
      rd_idx = '0;
    end
  end

  assign rd_data      = best_scores[rd_idx];
  assign wr_idx       = IDX_W'(pos);
  assign pos_at_top   = (pos == '0);
  assign pos_in_table = (pos < POS_W'(TABLE_ENTRIES));
  // strictly smaller entries move down; equal ones stay above the newcomer
  assign shift_down   = !pos_at_top && (rd_data < score_q);

  // Checksum term select
  always_comb begin
    if (step < STEP_W'(TABLE_ENTRIES)) begin
      mac_operand = rd_data;
      mac_weight  = WGT_W'(step) + WGT_W'(3);
    end else if (step == STEP_W'(TABLE_ENTRIES)) begin
      mac_operand = play_counter;
      mac_weight  = WGT_W'(WGT_COUNT);
    end else if (step == STEP_W'(TABLE_ENTRIES + 1)) begin
      mac_operand = frame_total[15:0];
      mac_weight  = WGT_W'(WGT_FRAME_LO);
    end else begin
      mac_operand = frame_total[31:16];
      mac_weight  = WGT_W'(WGT_FRAME_HI);
    end
  end

  // Seed the accumulator as the insertion finishes; accumulate through ST_SUM
  assign mac_ctrl.load = (state == ST_INSERT) && !shift_down;
  assign mac_ctrl.step = (state == ST_SUM);

  tkst_mac u_mac (
    .clk     (clk),
    .ctrl    (mac_ctrl),
    .operand (mac_operand),
    .weight  (mac_weight),
    .acc     (mac_acc)
  );

  // result register takes a new word once it is free
  assign res_load = (state == ST_DONE) && (!res_valid || result.ready);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      play_counter <= '0;
      frame_total  <= '0;
      pos          <= '0;
      step         <= '0;
      res_valid    <= 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        best_scores[i] <= '0;
      end
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (play.valid) begin
            score_q  <= play.new_score;
            frames_q <= play.play_frames_added;
            pos      <= POS_W'(TABLE_ENTRIES);
            state    <= ST_INSERT;
          end
        end
        ST_INSERT: begin
          if (shift_down) begin
            if (pos_in_table) begin
              best_scores[wr_idx] <= rd_data;
            end
            pos <= pos - POS_W'(1);
          end else begin
            if (pos_in_table) begin
              best_scores[wr_idx] <= score_q;
            end
            play_counter <= play_counter + CNT_W'(1);
            frame_total  <= frame_total + frames_q;
            step         <= '0;
            state        <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (step == STEP_W'(SUM_STEPS - 1)) begin
            state <= ST_DONE;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        ST_DONE: begin
          // hand off once the result register is free
          if (res_load) begin
            res_rank  <= RANK_W'(pos);
            res_chk   <= mac_acc;
            res_plays <= play_counter;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign play.ready             = (state == ST_IDLE) && !rst;
  assign result.valid           = res_valid;
  assign result.rank            = res_rank;
  assign result.record_checksum = res_chk;
  assign result.plays_so_far    = res_plays;

  // Table ordering check
  logic table_sorted;
  always_comb begin
    table_sorted = 1'b1;
    for (int i = 0; i < TABLE_ENTRIES - 1; i++) begin
      if (best_scores[i] < best_scores[i+1]) begin
        table_sorted = 1'b0;
      end
    end
  end

  a_table_sorted: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> table_sorted)
    else $error("score table lost descending order");

  a_walk_starts_bottom: assert property (@(posedge clk) disable iff (rst)
    play.valid && play.ready |=> state == ST_INSERT && pos == POS_W'(TABLE_ENTRIES))
    else $error("insertion walk did not start at the bottom");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SUM |-> step <= STEP_W'(SUM_STEPS - 1))
    else $error("checksum step out of range");

  a_counter_bump: assert property (@(posedge clk) disable iff (rst)
    state == ST_INSERT && !shift_down |=> play_counter == $past(play_counter) + CNT_W'(1))
    else $error("play counter not advanced at insertion end");

endmodule
